>>> design/mara_pkg.sv
package mara_pkg;

  // Width of a sample, an average and a threshold.
  localparam int unsigned SampleW = 12;

  // Configuration port geometry.
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = SampleW;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgLowThreshold  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgHighThreshold = 1'd1;

  // Threshold values after reset.
  localparam logic [SampleW-1:0] LowThresholdReset  = 12'd300;
  localparam logic [SampleW-1:0] HighThresholdReset = 12'd3800;

  // Alarm band handed from the register file to the evaluation stage.
  typedef struct packed {
    logic [SampleW-1:0] low;
    logic [SampleW-1:0] high;
  } thr_t;

endpackage

>>> design/mara_window.sv
module mara_window #(
  parameter int unsigned WINDOW = 5,
  parameter int unsigned SUM_W  = 15
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [mara_pkg::SampleW-1:0] sample_i,
  output logic                        s1_valid_o,
  input  logic                        s1_ready_i,
  output logic [mara_pkg::SampleW-1:0] s1_level_o,
  output logic [SUM_W-1:0]            s1_sum_o
);
  import mara_pkg::*;

  localparam int unsigned POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(WINDOW - 1);

  logic [SampleW-1:0] ring_q [WINDOW];
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic               s1_valid_q, s1_valid_d;
  logic [SampleW-1:0] s1_level_q;
  logic               accept;

  // A new item enters whenever the next stage is empty or draining.
  assign in_ready_o = !s1_valid_q || s1_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // The running sum drops the entry being overwritten and adds the new sample.
  always_comb begin
    sum_d = sum_q - SUM_W'(ring_q[pos_q]) + SUM_W'(sample_i);
    pos_d = (pos_q == LAST_POS) ? '0 : pos_q + POS_W'(1);
  end

  // Stage one holds the item until the evaluation stage takes it.
  always_comb begin
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_ready_i) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  // Ring, write position and running sum; the ring starts out all zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        ring_q[i] <= '0;
      end
      pos_q      <= '0;
      sum_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (accept) begin
        ring_q[pos_q] <= sample_i;
        pos_q         <= pos_d;
        sum_q         <= sum_d;
      end
    end
  end

  // The sample itself travels alongside the sum.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_level_q <= sample_i;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_level_o = s1_level_q;
  assign s1_sum_o   = sum_q;

endmodule

>>> design/mara_eval.sv
module mara_eval #(
  parameter int unsigned WINDOW = 5,
  parameter int unsigned SUM_W  = 15
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mara_pkg::thr_t               thr_i,
  input  logic                         s1_valid_i,
  output logic                         s1_ready_o,
  input  logic [mara_pkg::SampleW-1:0] s1_level_i,
  input  logic [SUM_W-1:0]             s1_sum_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mara_pkg::SampleW-1:0] level_o,
  output logic [mara_pkg::SampleW-1:0] average_o,
  output logic                         changed_o,
  output logic                         anomaly_o
);
  import mara_pkg::*;

  // Reciprocal of WINDOW, exact for every sum below 2**SUM_W.
  localparam int unsigned SHIFT  = SUM_W + ((WINDOW > 1) ? $clog2(WINDOW) : 0);
  localparam longint unsigned RECIP_L = ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1)
                                        / 64'(WINDOW);
  localparam logic [SHIFT:0] RECIP = RECIP_L[SHIFT:0];
  localparam int unsigned PROD_W = SUM_W + SHIFT + 1;

  logic [PROD_W-1:0]  prod;
  logic [SampleW-1:0] avg;
  logic               changed, anomaly, load;
  logic               out_valid_q, out_valid_d;
  logic [SampleW-1:0] level_q, avg_q, last_avg_q;
  logic               changed_q, anomaly_q, last_valid_q;

  // The result register takes a new item when empty or being read.
  assign s1_ready_o = !out_valid_q || out_ready_i;
  assign load       = s1_valid_i && s1_ready_o;

  // Average by reciprocal multiply, then change and band checks.
  always_comb begin
    prod    = PROD_W'(s1_sum_i) * PROD_W'(RECIP);
    avg     = prod[SHIFT +: SampleW];
    changed = !last_valid_q || (avg != last_avg_q);
    anomaly = (avg > thr_i.high) || (avg < thr_i.low);
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state: result valid and the last reported average.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      last_valid_q <= 1'b0;
      last_avg_q   <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (load) begin
        last_valid_q <= 1'b1;
        last_avg_q   <= avg;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      level_q   <= s1_level_i;
      avg_q     <= avg;
      changed_q <= changed;
      anomaly_q <= anomaly;
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;
  assign average_o   = avg_q;
  assign changed_o   = changed_q;
  assign anomaly_o   = anomaly_q;

endmodule

>>> design/moving_average_range_alarm_unit.sv
// Moving average range alarm. Each 12-bit sample item enters a ring of WINDOW
// entries (all zero after reset, so the first averages include those zeros),
// and one result item leaves per sample: the sample, the truncated mean of
// the ring, a changed flag (always set on the first result after reset) and
// an anomaly flag for a mean above high_threshold or below low_threshold.
// Throughput is one item per clock cycle while out_ready_i is high. Accepting a
// sample updates the running sum register (stage one); the result register then
// takes that sum times the reciprocal of WINDOW and the compares.
// Thresholds are written through cfg_we_i/cfg_idx_i/cfg_data_i while idle.
module moving_average_range_alarm_unit #(
  parameter int unsigned WINDOW = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mara_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mara_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mara_pkg::SampleW-1:0]  sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mara_pkg::SampleW-1:0]  level_o,
  output logic [mara_pkg::SampleW-1:0]  average_o,
  output logic                          changed_o,
  output logic                          anomaly_o
);
  import mara_pkg::*;

  localparam int unsigned SUM_W = $clog2(WINDOW * ((1 << SampleW) - 1) + 1);

  thr_t               thr_q;
  logic               s1_valid, s1_ready;
  logic [SampleW-1:0] s1_level;
  logic [SUM_W-1:0]   s1_sum;

  // Threshold registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.low  <= LowThresholdReset;
      thr_q.high <= HighThresholdReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLowThreshold:  thr_q.low  <= cfg_data_i;
        CfgHighThreshold: thr_q.high <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Ring and running sum.
  mara_window #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_i   (sample_i),
    .s1_valid_o (s1_valid),
    .s1_ready_i (s1_ready),
    .s1_level_o (s1_level),
    .s1_sum_o   (s1_sum)
  );

  // Average, flags and result register.
  mara_eval #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .thr_i       (thr_q),
    .s1_valid_i  (s1_valid),
    .s1_ready_o  (s1_ready),
    .s1_level_i  (s1_level),
    .s1_sum_i    (s1_sum),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .level_o     (level_o),
    .average_o   (average_o),
    .changed_o   (changed_o),
    .anomaly_o   (anomaly_o)
  );

endmodule
